@@ hdl/pub_pkg.sv @@
// package for the particle update / bounds block
// shared widths, record types and helper functions; no dependencies
package pub_pkg;
	localparam int CB = 16;
	localparam int FB = 8;
	localparam logic signed [CB-1:0] SMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] SMIN = {1'b1, {(CB-1){1'b0}}};

	typedef struct packed {
		logic [3*CB-1:0] position;
		logic [3*CB-1:0] velocity;
		logic [3*CB-1:0] acceleration;
		logic [2*CB-1:0] spin;
		logic [CB-1:0]   age;
		logic [CB-1:0]   lifespan;
		logic [2*CB-1:0] scale_start;
		logic [2*CB-1:0] scale_end;
		logic [31:0]     colour_start;
		logic [31:0]     colour_end;
		logic            is_alive;
		logic            final_item;
	} in_word_t;

	typedef struct packed {
		logic [3*CB-1:0]       new_position;
		logic [3*CB-1:0]       new_velocity;
		logic signed [CB-1:0]  new_rotation;
		logic [CB-1:0]         new_age;
		logic [2*CB-1:0]       scale_now;
		logic [31:0]           colour_now;
		logic                  still_alive;
		logic [3*CB-1:0]       bound_min;
		logic [3*CB-1:0]       bound_max;
		logic                  pass_done;
	} out_word_t;

	// queue entry: record plus lerp factor
	typedef struct packed {
		in_word_t        rec;
		logic [8:0]      f;
	} job_t;

	function automatic logic signed [CB-1:0] sat_add(input logic signed [CB:0] v);
		if (v > $signed({SMAX[CB-1], SMAX})) return SMAX;
		if (v < $signed({SMIN[CB-1], SMIN})) return SMIN;
		return v[CB-1:0];
	endfunction

	// a + floor(v*tick/256), saturated
	function automatic logic signed [CB-1:0] integ(input logic signed [CB-1:0] a,
			input logic signed [CB-1:0] v, input logic [CB-1:0] tick);
		logic signed [2*CB:0] p;
		logic signed [CB+FB:0] s;
		p = v * $signed({1'b0, tick});
		s = $signed(p[2*CB:FB]) + a;
		if (s > $signed({{(FB+1){1'b0}}, SMAX})) return SMAX;
		if (s < $signed({{(FB+1){1'b1}}, SMIN})) return SMIN;
		return s[CB-1:0];
	endfunction
endpackage

@@ hdl/pub_if.sv @@
// valid/ready channel interface carrying one word of type T
// the word type comes in as the parameter T; no package dependency
interface pub_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/pub_front.sv @@
// front: accepts records, finds lerp factor with a serial divider
// depends on pub_pkg
module pub_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pub_pkg::in_word_t in_data,
	output logic             q_valid,
	input  logic             q_ready,
	output pub_pkg::job_t    q_data
);
	import pub_pkg::*;
	logic busy_q;
	logic [4:0] cnt_q;
	in_word_t rec_q;
	logic [CB+FB-1:0] num_q;
	logic [CB:0] rem_q;
	logic [CB+FB-1:0] quo_q;
	logic done_q;
	logic [CB:0] trial;
	logic [CB+FB-1:0] qf;
	localparam logic [4:0] STEPS = 5'(CB + FB);

	assign in_ready = !busy_q;
	assign trial = {rem_q[CB-1:0], num_q[CB+FB-1]} - {1'b0, rec_q.lifespan};
	assign q_valid = done_q;
	always_comb begin
		qf = quo_q;
		q_data.rec = rec_q;
		if (rec_q.lifespan == '0 || qf > 24'(256)) q_data.f = 9'd256;
		else q_data.f = qf[8:0];
	end

	// restoring divide, one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q && !done_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == STEPS - 5'd1) done_q <= 1'b1;
		end else if (done_q && q_ready) begin
			done_q <= 1'b0;
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rec_q <= in_data;
			num_q <= {in_data.age, {FB{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q && !done_q) begin
			num_q <= {num_q[CB+FB-2:0], 1'b0};
			if (!trial[CB]) begin
				rem_q <= trial;
				quo_q <= {quo_q[CB+FB-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CB-1:0], num_q[CB+FB-1]};
				quo_q <= {quo_q[CB+FB-2:0], 1'b0};
			end
		end
	end
endmodule

@@ hdl/pub_queue.sv @@
// two-entry queue between front and back
// depends on pub_pkg
module pub_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          w_valid,
	output logic          w_ready,
	input  pub_pkg::job_t w_data,
	output logic          r_valid,
	input  logic          r_ready,
	output pub_pkg::job_t r_data
);
	import pub_pkg::*;
	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;
	assign w_ready = cnt_q != 2'd2;
	assign r_valid = cnt_q != 2'd0;
	assign r_data = mem_q[rp_q];
	assign wr = w_valid && w_ready;
	assign rd = r_valid && r_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= w_data;
	end
endmodule

@@ hdl/pub_back.sv @@
// back: integration, lerp, age and bounding box accumulation
// depends on pub_pkg
module pub_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [pub_pkg::CB-1:0] tick,
	input  logic             j_valid,
	output logic             j_ready,
	input  pub_pkg::job_t    j_data,
	output logic             o_valid,
	input  logic             o_ready,
	output pub_pkg::out_word_t o_data
);
	import pub_pkg::*;
	logic v_s1;
	job_t j_s1;
	logic signed [CB-1:0] np_s1 [3];
	logic signed [CB-1:0] nv_s1 [3];
	logic signed [CB-1:0] nr_s1;
	logic signed [CB-1:0] sx_s1, sy_s1;
	logic [31:0] col_s1;
	logic [CB-1:0] nage_s1;
	logic ov_q;
	out_word_t o_q;
	logic [3*CB-1:0] lo_q, hi_q;
	logic adv1, take;
	logic signed [CB-1:0] np [3];
	logic signed [CB-1:0] nv [3];
	logic signed [CB-1:0] sx, sy, half, mx;
	logic [31:0] col;
	logic [CB:0] asum;
	logic [3*CB-1:0] lo_n, hi_n;
	logic still;

	function automatic logic signed [CB-1:0] lerp(input logic signed [CB-1:0] a,
			input logic signed [CB-1:0] b, input logic [8:0] f);
		logic signed [CB+10:0] p;
		p = ($signed({b[CB-1], b}) - $signed({a[CB-1], a})) * $signed({1'b0, f});
		return CB'($signed(p[CB+10:FB]) + a);
	endfunction

	assign adv1 = !ov_q || o_ready;
	assign take = j_valid && (!v_s1 || adv1);
	assign j_ready = !v_s1 || adv1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			np[i] = integ(j_data.rec.position[i*CB+:CB], j_data.rec.velocity[i*CB+:CB], tick);
			nv[i] = integ(j_data.rec.velocity[i*CB+:CB],
				j_data.rec.acceleration[i*CB+:CB], tick);
		end
		sx = lerp(j_data.rec.scale_start[CB-1:0], j_data.rec.scale_end[CB-1:0], j_data.f);
		sy = lerp(j_data.rec.scale_start[2*CB-1:CB], j_data.rec.scale_end[2*CB-1:CB],
			j_data.f);
		for (int i = 0; i < 4; i++) begin
			col[i*8+:8] = 8'(lerp(CB'(j_data.rec.colour_start[i*8+:8]),
				CB'(j_data.rec.colour_end[i*8+:8]), j_data.f));
		end
		asum = {1'b0, j_data.rec.age} + {1'b0, tick};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (take) v_s1 <= 1'b1;
		else if (adv1) v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			j_s1 <= j_data;
			np_s1 <= np;
			nv_s1 <= nv;
			nr_s1 <= integ(j_data.rec.spin[CB-1:0], j_data.rec.spin[2*CB-1:CB], tick);
			sx_s1 <= sx;
			sy_s1 <= sy;
			col_s1 <= col;
			nage_s1 <= asum[CB] ? {CB{1'b1}} : asum[CB-1:0];
		end
	end

	// box update from stage 1
	always_comb begin
		logic signed [CB-1:0] l, h, bl, bh;
		mx = (sx_s1 > sy_s1) ? sx_s1 : sy_s1;
		half = mx >>> 1;
		for (int i = 0; i < 3; i++) begin
			l = sat_add($signed({np_s1[i][CB-1], np_s1[i]}) - $signed({half[CB-1], half}));
			h = sat_add($signed({np_s1[i][CB-1], np_s1[i]}) + $signed({half[CB-1], half}));
			bl = lo_q[i*CB+:CB];
			bh = hi_q[i*CB+:CB];
			if (l < bl) bl = l;
			if (h < bl) bl = h;
			if (l > bh) bh = l;
			if (h > bh) bh = h;
			if (!j_s1.rec.is_alive) begin
				bl = lo_q[i*CB+:CB];
				bh = hi_q[i*CB+:CB];
			end
			lo_n[i*CB+:CB] = bl;
			hi_n[i*CB+:CB] = bh;
		end
		still = nage_s1 <= j_s1.rec.lifespan;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
		end else begin
			if (v_s1 && adv1) begin
				ov_q <= 1'b1;
				if (j_s1.rec.final_item) begin
					lo_q <= '0;
					hi_q <= '0;
				end else begin
					lo_q <= lo_n;
					hi_q <= hi_n;
				end
			end else if (o_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv1) begin
			if (j_s1.rec.is_alive) begin
				o_q.new_position <= {np_s1[2], np_s1[1], np_s1[0]};
				o_q.new_velocity <= {nv_s1[2], nv_s1[1], nv_s1[0]};
				o_q.new_rotation <= nr_s1;
				o_q.new_age <= nage_s1;
				o_q.scale_now <= {sy_s1, sx_s1};
				o_q.colour_now <= col_s1;
				o_q.still_alive <= still;
			end else begin
				o_q.new_position <= j_s1.rec.position;
				o_q.new_velocity <= j_s1.rec.velocity;
				o_q.new_rotation <= j_s1.rec.spin[CB-1:0];
				o_q.new_age <= j_s1.rec.age;
				o_q.scale_now <= '0;
				o_q.colour_now <= '0;
				o_q.still_alive <= 1'b0;
			end
			o_q.bound_min <= j_s1.rec.final_item ? lo_n : '0;
			o_q.bound_max <= j_s1.rec.final_item ? hi_n : '0;
			o_q.pass_done <= j_s1.rec.final_item;
		end
	end

	assign o_valid = ov_q;
	assign o_data = o_q;
endmodule

@@ hdl/particle_update_bounds_core.sv @@
// top level of the particle update / bounds block
// depends on pub_pkg, pub_if, pub_front, pub_queue, pub_back
//
// channel | dir | word
// cfg     | in  | time_step, 16 bits
// din     | in  | one particle record (pub_pkg::in_word_t)
// dout    | out | one updated record plus box (pub_pkg::out_word_t)
//
// front takes a word, then runs a bit-serial divider (age/lifespan) and takes no new
// word until the quotient has gone to the queue; the divider sets the rate
// back runs two registered stages behind a two-entry queue, each side stalls alone
// arst_n clears handshake state, time_step and the box (origin)
module particle_update_bounds_core (
	input logic clk,
	input logic arst_n,
	pub_if.sink   cfg,
	pub_if.sink   din,
	pub_if.source dout
);
	import pub_pkg::*;
	logic [CB-1:0] tick_q;
	logic qw_valid, qw_ready, qr_valid, qr_ready;
	job_t qw_data, qr_data;

	// config register, always ready
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tick_q <= '0;
		else if (cfg.valid) tick_q <= cfg.data[CB-1:0];
	end

	pub_front u_front (
		.clk, .arst_n,
		.in_valid(din.valid), .in_ready(din.ready), .in_data(din.data),
		.q_valid(qw_valid), .q_ready(qw_ready), .q_data(qw_data)
	);

	pub_queue u_queue (
		.clk, .arst_n,
		.w_valid(qw_valid), .w_ready(qw_ready), .w_data(qw_data),
		.r_valid(qr_valid), .r_ready(qr_ready), .r_data(qr_data)
	);

	pub_back u_back (
		.clk, .arst_n, .tick(tick_q),
		.j_valid(qr_valid), .j_ready(qr_ready), .j_data(qr_data),
		.o_valid(dout.valid), .o_ready(dout.ready), .o_data(dout.data)
	);

`ifndef SYNTH
	// box emitted only with the final word
	a_box: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.data.pass_done |-> dout.data.bound_min == '0)
		else $error("box leaked on non-final word");
	// result word held while it waits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.ready |=> dout.valid && $stable(dout.data))
		else $error("result word changed while waiting");
	// front busy while a word waits in the divider
	a_front: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> !din.ready)
		else $error("front took two words");
`endif
endmodule

@@ tb/particle_update_bounds_core_test.sv @@
// self-checking testbench for particle_update_bounds_core
// needs pub_pkg, pub_if and the block's rtl; predicts every result word in plain sv
module particle_update_bounds_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pub_pkg::*;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t e;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;

	pub_if #(.T(logic [CB-1:0])) cfg_ch (clk);
	pub_if #(.T(in_word_t))      din_ch (clk);
	pub_if #(.T(out_word_t))     dout_ch (clk);

	particle_update_bounds_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch.sink),
		.din    (din_ch.sink),
		.dout   (dout_ch.source)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// predictor state: frame tick and running box, one entry per axis
	logic [CB-1:0] tick;
	longint box_lo [3];
	longint box_hi [3];

	out_word_t pending_words[$];
	int errors = 0;
	bit quiet = 0;
	int sink_hold = 0;
	int stall_cycles = 0;
	stim_row_t rows[$];

	function automatic longint sx(logic [CB-1:0] x);
		return longint'($signed(x));
	endfunction

	function automatic longint clamp_q(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// a + floor(v*tick/256), saturated; >>> on longint rounds toward minus infinity
	function automatic longint euler_step(longint a, longint v);
		return clamp_q(a + ((v * longint'(tick)) >>> FB));
	endfunction

	function automatic out_word_t predict_update(in_word_t w);
		out_word_t r;
		longint f, sxv, syv, half, p, lo, hi, ca, cb, nage;
		r = '0;
		r.pass_done = w.final_item;
		if (!w.is_alive) begin
			// dead particle: kinematics pass through, box untouched
			r.new_position = w.position;
			r.new_velocity = w.velocity;
			r.new_rotation = w.spin[CB-1:0];
			r.new_age = w.age;
		end else begin
			for (int i = 0; i < 3; i++) begin
				r.new_position[CB*i +: CB] = CB'(euler_step(sx(w.position[CB*i +: CB]),
					sx(w.velocity[CB*i +: CB])));
				r.new_velocity[CB*i +: CB] = CB'(euler_step(sx(w.velocity[CB*i +: CB]),
					sx(w.acceleration[CB*i +: CB])));
			end
			r.new_rotation = CB'(euler_step(sx(w.spin[CB-1:0]), sx(w.spin[2*CB-1:CB])));
			// lerp factor, full when lifespan is zero
			if (w.lifespan == 0) f = 256;
			else begin
				f = (longint'(w.age) * 256) / longint'(w.lifespan);
				if (f > 256) f = 256;
			end
			sxv = sx(w.scale_start[CB-1:0]);
			sxv = sxv + (((sx(w.scale_end[CB-1:0]) - sxv) * f) >>> FB);
			syv = sx(w.scale_start[2*CB-1:CB]);
			syv = syv + (((sx(w.scale_end[2*CB-1:CB]) - syv) * f) >>> FB);
			r.scale_now = {CB'(syv), CB'(sxv)};
			for (int i = 0; i < 4; i++) begin
				ca = longint'(w.colour_start[8*i +: 8]);
				cb = longint'(w.colour_end[8*i +: 8]);
				r.colour_now[8*i +: 8] = 8'(ca + (((cb - ca) * f) >>> FB));
			end
			nage = longint'(w.age) + longint'(tick);
			if (nage > 65535) nage = 65535;
			r.new_age = CB'(nage);
			r.still_alive = (nage > longint'(w.lifespan)) ? 1'b0 : 1'b1;
			// half size from the larger scale, floor even when negative
			half = ((sxv > syv) ? sxv : syv) >>> 1;
			for (int i = 0; i < 3; i++) begin
				p = sx(r.new_position[CB*i +: CB]);
				lo = clamp_q(p - half);
				hi = clamp_q(p + half);
				if (lo < box_lo[i]) box_lo[i] = lo;
				if (hi < box_lo[i]) box_lo[i] = hi;
				if (lo > box_hi[i]) box_hi[i] = lo;
				if (hi > box_hi[i]) box_hi[i] = hi;
			end
		end
		if (w.final_item) begin
			for (int i = 0; i < 3; i++) begin
				r.bound_min[CB*i +: CB] = CB'(box_lo[i]);
				r.bound_max[CB*i +: CB] = CB'(box_hi[i]);
				box_lo[i] = 0;
				box_hi[i] = 0;
			end
		end
		return r;
	endfunction

	task automatic compare_word(out_word_t e, out_word_t a);
		if (a.new_position !== e.new_position) begin
			$error("new_position exp %h got %h", e.new_position, a.new_position); errors++;
		end
		if (a.new_velocity !== e.new_velocity) begin
			$error("new_velocity exp %h got %h", e.new_velocity, a.new_velocity); errors++;
		end
		if (a.new_rotation !== e.new_rotation) begin
			$error("new_rotation exp %h got %h", e.new_rotation, a.new_rotation); errors++;
		end
		if (a.new_age !== e.new_age) begin
			$error("new_age exp %h got %h", e.new_age, a.new_age); errors++;
		end
		if (a.scale_now !== e.scale_now) begin
			$error("scale_now exp %h got %h", e.scale_now, a.scale_now); errors++;
		end
		if (a.colour_now !== e.colour_now) begin
			$error("colour_now exp %h got %h", e.colour_now, a.colour_now); errors++;
		end
		if (a.still_alive !== e.still_alive) begin
			$error("still_alive exp %b got %b", e.still_alive, a.still_alive); errors++;
		end
		if (a.bound_min !== e.bound_min) begin
			$error("bound_min exp %h got %h", e.bound_min, a.bound_min); errors++;
		end
		if (a.bound_max !== e.bound_max) begin
			$error("bound_max exp %h got %h", e.bound_max, a.bound_max); errors++;
		end
		if (a.pass_done !== e.pass_done) begin
			$error("pass_done exp %b got %b", e.pass_done, a.pass_done); errors++;
		end
	endtask

	// result side: random ready bursts, none while quiet
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			dout_ch.ready <= 0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			sink_hold <= $urandom_range(0, 16);
			dout_ch.ready <= 0;
		end else begin
			dout_ch.ready <= 1;
		end
	end

	// result checker against the oldest predicted word
	always @(posedge clk) begin
		if (arst_n && dout_ch.valid && dout_ch.ready) begin
			if (pending_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else
				compare_word(pending_words.pop_front(), dout_ch.data);
		end
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == 3000) begin
			$display("particle_update_bounds_core_test NOT OK");
			$finish;
		end
	end

	// random sender gap, valid dropped meanwhile
	task automatic maybe_gap();
		int n;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 17);
			din_ch.valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	// offer one record and wait until taken; valid stays high for a following word
	task automatic send_record(in_word_t w, bit typed, out_word_t e);
		out_word_t p;
		maybe_gap();
		din_ch.valid <= 1;
		din_ch.data <= w;
		do @(posedge clk); while (!din_ch.ready);
		p = predict_update(w);
		pending_words = {pending_words, (typed ? e : p)};
	endtask

	// tick change only once the block has drained, plus its divider latency
	task automatic write_tick(logic [CB-1:0] v);
		din_ch.valid <= 0;
		wait (pending_words.size() == 0);
		repeat (40) @(posedge clk);
		cfg_ch.valid <= 1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
		tick = v;
	endtask

	function automatic logic [CB-1:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'hFFFF;
			3: return 16'h0000;
			4, 5: return CB'($urandom_range(0, 1023)) - 16'd512;
			default: return CB'($urandom);
		endcase
	endfunction

	function automatic in_word_t rand_record();
		in_word_t w;
		w.position = {rand_comp(), rand_comp(), rand_comp()};
		w.velocity = {rand_comp(), rand_comp(), rand_comp()};
		w.acceleration = {rand_comp(), rand_comp(), rand_comp()};
		w.spin = {rand_comp(), rand_comp()};
		w.scale_start = {rand_comp(), rand_comp()};
		w.scale_end = {rand_comp(), rand_comp()};
		w.colour_start = $urandom;
		w.colour_end = $urandom;
		// lifetimes: mostly ordinary, some zero, top and past due
		case ($urandom_range(0, 7))
			0: begin w.lifespan = 0; w.age = CB'($urandom); end
			1: begin w.lifespan = 16'hFFFF; w.age = CB'($urandom); end
			2: begin w.lifespan = CB'($urandom); w.age = 16'hFFFF; end
			default: begin
				w.lifespan = CB'($urandom_range(1, 16'h4000));
				w.age = CB'($urandom_range(0, w.lifespan));
			end
		endcase
		w.is_alive = ($urandom_range(0, 6) != 0);
		w.final_item = ($urandom_range(0, 7) == 0);
		return w;
	endfunction

	task automatic add_row(in_word_t w, bit typed);
		stim_row_t r;
		r.w = w;
		r.typed = typed;
		r.e = '0;
		// typed rows are dead records: pass-through, box untouched
		r.e.new_position = w.position;
		r.e.new_velocity = w.velocity;
		r.e.new_rotation = w.spin[CB-1:0];
		r.e.new_age = w.age;
		r.e.pass_done = w.final_item;
		rows = {rows, r};
	endtask

	task automatic build_table();
		in_word_t w;
		// dead, all ones
		w = '1; w.is_alive = 0; w.final_item = 0; add_row(w, 1);
		// dead final with the box still at the origin
		w = '0; w.final_item = 1; add_row(w, 1);
		// live at the positive extremes
		w = '0; w.is_alive = 1;
		w.position = {3{16'h7FFF}}; w.velocity = {3{16'h7FFF}};
		w.acceleration = {3{16'h7FFF}}; w.spin = {16'h7FFF, 16'h7FFF};
		w.lifespan = 16'h0100; w.age = 16'h0080;
		w.scale_start = {2{16'h7FFF}}; w.scale_end = {2{16'h7FFF}};
		w.colour_start = 32'h0000_0000; w.colour_end = 32'hFFFF_FFFF;
		add_row(w, 0);
		// live at the negative extremes
		w.position = {3{16'h8000}}; w.velocity = {3{16'h8000}};
		w.acceleration = {3{16'h8000}}; w.spin = {16'h8000, 16'h8000};
		w.colour_start = 32'hFFFF_FFFF; w.colour_end = 32'h0000_0000;
		add_row(w, 0);
		// lifespan zero: factor full
		w.lifespan = 0; w.age = 16'h1234; add_row(w, 0);
		// age past lifespan: factor clamped, particle dies
		w.lifespan = 16'h0100; w.age = 16'h0300; add_row(w, 0);
		// lifespan at top never dies, age saturates
		w.lifespan = 16'hFFFF; w.age = 16'hFFFF; add_row(w, 0);
		// negative scale, so the half is negative
		w.position = 48'h0100_FF00_0010; w.velocity = 48'h0010_FFF0_0001;
		w.scale_start = {16'hFFF3, 16'hFF81}; w.scale_end = {16'hFE01, 16'hFFFF};
		w.age = 16'h0040; w.lifespan = 16'h0200; add_row(w, 0);
		// positive scale widens the box, emitted here
		w.scale_start = {16'h0301, 16'h0100}; w.scale_end = {16'h0500, 16'h0201};
		w.final_item = 1; add_row(w, 0);
		// live particle then dead final: box carries live one only
		w.final_item = 0; w.position = 48'h7F00_8100_0123; add_row(w, 0);
		w = '1; w.is_alive = 0; w.final_item = 1; add_row(w, 0);
		// live final alone
		w = '0; w.is_alive = 1; w.final_item = 1; w.spin = 32'h0100_FFFF;
		w.position = 48'hC000_4000_0001; w.velocity = 48'h0200_FE00_0000;
		w.scale_start = 32'h0200_0200; w.scale_end = 32'h0400_0200; w.lifespan = 16'h0100;
		add_row(w, 0);
	endtask

	initial begin
		logic [CB-1:0] ticks [6];
		cfg_ch.valid = 0;
		cfg_ch.data = '0;
		din_ch.valid = 0;
		din_ch.data = '0;
		dout_ch.ready = 0;
		tick = '0;
		for (int i = 0; i < 3; i++) begin
			box_lo[i] = 0;
			box_hi[i] = 0;
		end
		build_table();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed rows at the reset tick, then again at the largest tick
		foreach (rows[i]) send_record(rows[i].w, rows[i].typed, rows[i].e);
		write_tick(16'hFFFF);
		foreach (rows[i]) send_record(rows[i].w, rows[i].typed, rows[i].e);

		// random phases, each with its own tick; the last runs without idling
		ticks[0] = 16'h0100;
		ticks[1] = 16'h0000;
		ticks[2] = CB'($urandom);
		ticks[3] = 16'h0001;
		ticks[4] = 16'hFFFF;
		ticks[5] = 16'h0010 + CB'($urandom_range(0, 255));
		for (int ph = 0; ph < 6; ph++) begin
			write_tick(ticks[ph]);
			quiet = (ph == 3 || ph == 5);
			repeat (108) send_record(rand_record(), 0, '0);
		end
		din_ch.valid <= 0;

		wait (pending_words.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("particle_update_bounds_core_test OK");
		else
			$display("particle_update_bounds_core_test NOT OK");
		$finish;
	end
endmodule

@@ filelist.f @@
hdl/pub_pkg.sv
hdl/pub_if.sv
hdl/pub_front.sv
hdl/pub_queue.sv
hdl/pub_back.sv
hdl/particle_update_bounds_core.sv
tb/particle_update_bounds_core_test.sv
